### src/relocation_masked_window_compare_assert.svh
// assertion macros shared by the rmwc modules
`ifndef RELOCATION_MASKED_WINDOW_COMPARE_ASSERT_SVH
`define RELOCATION_MASKED_WINDOW_COMPARE_ASSERT_SVH

// same-cycle implication
`define RMWC_AST_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmwc assertion failed");

// next-cycle implication
`define RMWC_AST_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmwc assertion failed");

`endif

### src/rmwc_pkg.sv
package rmwc_pkg;

    localparam int unsigned WINDOW_BYTES_DEF = 32;
    localparam logic [5:0]  MIN_CMP_RST      = 6'd16;

    localparam int unsigned OFS_W = 12;
    localparam logic [15:0] OFS_MASK = 16'h0FFF;
    localparam int unsigned LO_W  = 8;

    localparam logic [2:0] ACT_START  = 3'd0;
    localparam logic [2:0] ACT_HEADER = 3'd1;
    localparam logic [2:0] ACT_ENTRY  = 3'd2;
    localparam logic [2:0] ACT_PAIR   = 3'd3;
    localparam logic [2:0] ACT_FINISH = 3'd4;

    localparam logic [3:0] TYP_ABS     = 4'd0;
    localparam logic [3:0] TYP_HIGH    = 4'd1;
    localparam logic [3:0] TYP_LOW     = 4'd2;
    localparam logic [3:0] TYP_HIGHLOW = 4'd3;
    localparam logic [3:0] TYP_HIGHADJ = 4'd4;

    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_START  = 3'd1;
    localparam logic [2:0] OP_MARK2  = 3'd2;
    localparam logic [2:0] OP_MARK4  = 3'd3;
    localparam logic [2:0] OP_ERR    = 3'd4;
    localparam logic [2:0] OP_PAIR   = 3'd5;
    localparam logic [2:0] OP_FINISH = 3'd6;

    localparam logic [1:0] VERD_CLEAN   = 2'd0;
    localparam logic [1:0] VERD_ANOMALY = 2'd1;
    localparam logic [1:0] VERD_ERROR   = 2'd2;

    typedef struct packed {
        logic [2:0]             op;
        logic signed [LO_W-1:0] lo;
        logic [7:0]             live;
        logic [7:0]             clean;
    } t_cmd;

endpackage

### src/rmwc_in_if.sv
interface rmwc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [31:0] window_start;
    logic [31:0] page_rva;
    logic [15:0] entry_word;
    logic        last_in_block;
    logic [7:0]  live_byte;
    logic [7:0]  clean_byte;

    modport source (
        output valid, action, window_start, page_rva, entry_word, last_in_block,
               live_byte, clean_byte,
        input  ready
    );
    modport sink (
        input  valid, action, window_start, page_rva, entry_word, last_in_block,
               live_byte, clean_byte,
        output ready
    );
endinterface

### src/rmwc_out_if.sv
interface rmwc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;
    logic [5:0] compared_count;

    modport source (
        output valid, verdict, compared_count,
        input  ready
    );
    modport sink (
        input  valid, verdict, compared_count,
        output ready
    );
endinterface

### src/rmwc_front.sv
module rmwc_front #(
    parameter int unsigned WINDOW_BYTES = rmwc_pkg::WINDOW_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rmwc_in_if.sink        i_in,
    input  logic           i_q_full,
    output logic           o_push,
    output rmwc_pkg::t_cmd o_cmd
);
    import rmwc_pkg::*;

    localparam logic signed [33:0] WIN_HI = 34'(WINDOW_BYTES);

    logic [31:0]        r_wbase, n_wbase;
    logic [31:0]        r_block, n_block;
    logic signed [33:0] r_delta, n_delta;
    logic               r_skip, n_skip;

    logic               accept;
    logic [OFS_W-1:0]   ofs;
    logic [3:0]         typ;
    logic [32:0]        sum33;
    logic signed [33:0] rel;
    logic               in2, in4;
    logic [2:0]         op;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;

    assign ofs   = OFS_W'(i_in.entry_word & OFS_MASK);
    assign typ   = i_in.entry_word[15:12];
    assign sum33 = {1'b0, r_block} + 33'(ofs);
    assign rel   = r_delta + $signed(34'(ofs));
    assign in2   = (rel < WIN_HI) && (rel > -34'sd2);
    assign in4   = (rel < WIN_HI) && (rel > -34'sd4);

    always_comb begin
        op      = OP_NOP;
        n_wbase = r_wbase;
        n_block = r_block;
        n_delta = r_delta;
        n_skip  = r_skip;
        unique case (i_in.action)
            ACT_START: begin
                op      = OP_START;
                n_wbase = i_in.window_start;
                n_block = '0;
                n_delta = -$signed({2'b00, i_in.window_start});
                n_skip  = 1'b0;
            end
            ACT_HEADER: begin
                n_block = i_in.page_rva;
                n_delta = $signed({2'b00, i_in.page_rva}) - $signed({2'b00, r_wbase});
                n_skip  = 1'b0;
            end
            ACT_ENTRY: begin
                if (r_skip) begin
                    n_skip = 1'b0;
                end else if (sum33[32]) begin
                    op = OP_ERR;
                end else begin
                    unique case (typ)
                        TYP_ABS: begin
                            op = OP_NOP;
                        end
                        TYP_HIGH, TYP_LOW: begin
                            op = in2 ? OP_MARK2 : OP_NOP;
                        end
                        TYP_HIGHLOW: begin
                            op = in4 ? OP_MARK4 : OP_NOP;
                        end
                        TYP_HIGHADJ: begin
                            if (i_in.last_in_block) begin
                                op = OP_ERR;
                            end else begin
                                op     = in2 ? OP_MARK2 : OP_NOP;
                                n_skip = 1'b1;
                            end
                        end
                        default: begin
                            op = in4 ? OP_ERR : OP_NOP;
                        end
                    endcase
                end
            end
            ACT_PAIR: begin
                op = OP_PAIR;
            end
            ACT_FINISH: begin
                op = OP_FINISH;
            end
            default: begin
                op = OP_NOP;
            end
        endcase
    end

    assign o_push      = accept && (op != OP_NOP);
    assign o_cmd.op    = op;
    assign o_cmd.lo    = rel[LO_W-1:0];
    assign o_cmd.live  = i_in.live_byte;
    assign o_cmd.clean = i_in.clean_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wbase <= '0;
            r_block <= '0;
            r_delta <= '0;
            r_skip  <= 1'b0;
        end else if (accept) begin
            r_wbase <= n_wbase;
            r_block <= n_block;
            r_delta <= n_delta;
            r_skip  <= n_skip;
        end
    end

endmodule

### src/rmwc_queue.sv
`include "relocation_masked_window_compare_assert.svh"

module rmwc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rmwc_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output rmwc_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import rmwc_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    `RMWC_AST_IMP(a_q_bound, i_clk, i_rst_n, 1'b1, r_cnt <= 2'd2)
    `RMWC_AST_IMP(a_q_pop_valid, i_clk, i_rst_n, i_pop, r_cnt != 2'd0)
    `RMWC_AST_IMP(a_q_push_room, i_clk, i_rst_n, i_push, r_cnt != 2'd2)

endmodule

### src/rmwc_back.sv
`include "relocation_masked_window_compare_assert.svh"

module rmwc_back #(
    parameter int unsigned WINDOW_BYTES = rmwc_pkg::WINDOW_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  rmwc_pkg::t_cmd i_cmd,
    output logic           o_pop,
    input  logic           i_cfg_we,
    input  logic [5:0]     i_cfg_wdata,
    rmwc_out_if.source     o_out
);
    import rmwc_pkg::*;

    localparam int unsigned IDX_W = $clog2(WINDOW_BYTES);
    localparam int unsigned CNT_W = $clog2(WINDOW_BYTES + 1);
    localparam int unsigned CMP_W = LO_W + 2;

    logic [5:0]              r_min;
    logic [WINDOW_BYTES-1:0] r_mask;
    logic [CNT_W-1:0]        r_pos;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_mis;
    logic                    r_err;
    logic                    r_ovalid;
    logic [1:0]              r_verdict;
    logic [5:0]              r_ocount;

    logic                    go;
    logic [WINDOW_BYTES-1:0] mark;
    logic signed [CMP_W-1:0] lo_ext;
    logic signed [CMP_W-1:0] hi_ext;
    logic [1:0]              verdict;
    logic                    pos_ok;

    assign go = i_q_valid && ((i_cmd.op != OP_FINISH) || !r_ovalid || o_out.ready);
    assign o_pop = go;

    // byte i masked when lo <= i < lo + size, window-relative
    assign lo_ext = CMP_W'(i_cmd.lo);
    assign hi_ext = lo_ext + ((i_cmd.op == OP_MARK4) ? CMP_W'(4) : CMP_W'(2));

    always_comb begin
        for (int i = 0; i < WINDOW_BYTES; i++) begin
            mark[i] = ($signed(CMP_W'(i)) >= lo_ext) && ($signed(CMP_W'(i)) < hi_ext);
        end
    end

    assign pos_ok = (r_pos < CNT_W'(WINDOW_BYTES));

    always_comb begin
        if (r_err || (7'(WINDOW_BYTES) < {1'b0, r_min}) || pos_ok) begin
            verdict = VERD_ERROR;
        end else if (r_mis) begin
            verdict = VERD_ANOMALY;
        end else if (7'(r_cnt) >= {1'b0, r_min}) begin
            verdict = VERD_CLEAN;
        end else begin
            verdict = VERD_ERROR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_CMP_RST;
        end else if (i_cfg_we) begin
            r_min <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_pos  <= '0;
            r_cnt  <= '0;
            r_mis  <= 1'b0;
            r_err  <= 1'b0;
        end else if (go) begin
            unique case (i_cmd.op)
                OP_START: begin
                    r_mask <= '0;
                    r_pos  <= '0;
                    r_cnt  <= '0;
                    r_mis  <= 1'b0;
                    r_err  <= 1'b0;
                end
                OP_MARK2, OP_MARK4: begin
                    r_mask <= r_mask | mark;
                end
                OP_ERR: begin
                    r_err <= 1'b1;
                end
                OP_PAIR: begin
                    if (pos_ok) begin
                        if (!r_mask[r_pos[IDX_W-1:0]]) begin
                            r_cnt <= r_cnt + CNT_W'(1);
                            if (i_cmd.live != i_cmd.clean) begin
                                r_mis <= 1'b1;
                            end
                        end
                        r_pos <= r_pos + CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (go && (i_cmd.op == OP_FINISH)) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && (i_cmd.op == OP_FINISH)) begin
            r_verdict <= verdict;
            r_ocount  <= 6'(r_cnt);
        end
    end

    assign o_out.valid          = r_ovalid;
    assign o_out.verdict        = r_verdict;
    assign o_out.compared_count = r_ocount;

    `RMWC_AST_NXT(a_fin_out, i_clk, i_rst_n, go && (i_cmd.op == OP_FINISH), r_ovalid)
    `RMWC_AST_IMP(a_pos_lim, i_clk, i_rst_n, 1'b1, r_pos <= CNT_W'(WINDOW_BYTES))
    `RMWC_AST_NXT(a_start_clr, i_clk, i_rst_n, go && (i_cmd.op == OP_START), (r_pos == '0) && (r_mask == '0) && !r_err)

endmodule

### src/relocation_masked_window_compare.sv
// Relocation-masked window compare: a start beat fixes the window address, header and
// relocation entry beats build a byte mask over the window, byte-pair beats compare the
// unmasked bytes, and a finish beat returns one verdict with the compared byte count.
// The block takes one beat per clock while the queue is not full; the decode
// stage works out the entry target against the window with one 34-bit add and range check,
// and a two-beat queue feeds the execute stage, which updates the mask with one parallel
// compare per window byte. A finish beat waits in the execute stage only while an earlier
// verdict still sits unread in the output register. A verdict is loaded into the output
// register when the execute stage takes its finish beat from the queue. min_compared resets
// to 16; the user must write it only while idle, the block does not enforce this.
module relocation_masked_window_compare #(
    parameter int unsigned WINDOW_BYTES = rmwc_pkg::WINDOW_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmwc_in_if.sink    i_in,
    rmwc_out_if.source o_out,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_wdata
);
    import rmwc_pkg::*;

    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    t_cmd front_cmd;
    t_cmd back_cmd;

    rmwc_front #(
        .WINDOW_BYTES(WINDOW_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    rmwc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (back_cmd),
        .i_pop   (pop)
    );

    rmwc_back #(
        .WINDOW_BYTES(WINDOW_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (back_cmd),
        .o_pop       (pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out       (o_out)
    );

endmodule

### bench/relocation_masked_window_compare_test.sv
`timescale 1ns / 1ps

module relocation_masked_window_compare_test;
    import rmwc_pkg::*;

    localparam int unsigned WB          = WINDOW_BYTES_DEF;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_WAIT  = 8;
    localparam int unsigned IDLE_PCT    = 30;
    localparam logic [2:0]  ACT_MAX     = 3'd7;
    localparam logic [3:0]  TYP_MAX     = 4'd15;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] window_start;
        logic [31:0] page_rva;
        logic [15:0] entry_word;
        logic        last_in_block;
        logic [7:0]  live_byte;
        logic [7:0]  clean_byte;
    } t_beat;

    typedef struct packed {
        logic [1:0] verdict;
        logic [5:0] compared_count;
    } t_verdict;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [5:0] cfg_wdata;

    rmwc_in_if  in_if ();
    rmwc_out_if out_if ();

    relocation_masked_window_compare uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    t_beat       pend_beats[$];
    t_verdict    verdict_q[$];
    int unsigned n_items;
    int unsigned n_results;
    int unsigned n_errors;
    int unsigned n_cycles;
    bit          in_fire;
    bit          no_stall;
    logic [31:0] last_page;

    // predicted block state
    logic [31:0]   m_win;
    logic [31:0]   m_blk;
    logic [WB-1:0] m_mask;
    bit            m_skip;
    int unsigned   m_pos;
    int unsigned   m_cnt;
    bit            m_mism;
    bit            m_perr;
    logic [5:0]    m_min;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void report_bad(string msg);
        n_errors++;
        if (n_errors <= 10) begin
            $display("%s", msg);
        end
    endfunction

    function automatic void mask_span(logic [33:0] tgt, int unsigned size);
        logic [33:0] addr;
        for (int i = 0; i < WB; i++) begin
            addr = {2'b00, m_win} + 34'(i);
            if (addr < tgt + 34'(size) && tgt < addr + 34'd1) begin
                m_mask[i] = 1'b1;
            end
        end
    endfunction

    function automatic void take_reloc(logic [15:0] word, logic last);
        logic [3:0]  typ;
        logic [33:0] tgt;
        typ = word[15:12];
        tgt = {2'b00, m_blk} + 34'(word & OFS_MASK);
        if (m_skip) begin
            m_skip = 1'b0;
        end else if (tgt[33:32] != 2'b00) begin
            m_perr = 1'b1;
        end else begin
            case (typ)
                TYP_ABS: begin
                end
                TYP_HIGH, TYP_LOW: begin
                    mask_span(tgt, 2);
                end
                TYP_HIGHLOW: begin
                    mask_span(tgt, 4);
                end
                TYP_HIGHADJ: begin
                    if (last) begin
                        m_perr = 1'b1;
                    end else begin
                        mask_span(tgt, 2);
                        m_skip = 1'b1;
                    end
                end
                default: begin
                    if (tgt < {2'b00, m_win} + 34'(WB) && {2'b00, m_win} < tgt + 34'd4) begin
                        m_perr = 1'b1;
                    end
                end
            endcase
        end
    endfunction

    function automatic void track_beat(t_beat b);
        t_verdict v;
        case (b.action)
            ACT_START: begin
                m_win  = b.window_start;
                m_blk  = '0;
                m_mask = '0;
                m_skip = 1'b0;
                m_pos  = 0;
                m_cnt  = 0;
                m_mism = 1'b0;
                m_perr = 1'b0;
            end
            ACT_HEADER: begin
                m_blk  = b.page_rva;
                m_skip = 1'b0;
            end
            ACT_ENTRY: begin
                take_reloc(b.entry_word, b.last_in_block);
            end
            ACT_PAIR: begin
                if (m_pos < WB) begin
                    if (!m_mask[m_pos]) begin
                        m_cnt++;
                        if (b.live_byte != b.clean_byte) begin
                            m_mism = 1'b1;
                        end
                    end
                    m_pos++;
                end
            end
            ACT_FINISH: begin
                if (m_perr || WB < int'(m_min) || m_pos < WB) begin
                    v.verdict = VERD_ERROR;
                end else if (m_mism) begin
                    v.verdict = VERD_ANOMALY;
                end else if (m_cnt >= int'(m_min)) begin
                    v.verdict = VERD_CLEAN;
                end else begin
                    v.verdict = VERD_ERROR;
                end
                v.compared_count = 6'(m_cnt);
                verdict_q.push_back(v);
            end
            default: begin
            end
        endcase
    endfunction

    // input acceptance, prediction and result checking
    always @(posedge i_clk) begin
        t_verdict want;
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
        in_fire <= i_rst_n && in_if.valid && in_if.ready;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            track_beat({in_if.action, in_if.window_start, in_if.page_rva, in_if.entry_word,
                        in_if.last_in_block, in_if.live_byte, in_if.clean_byte});
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (verdict_q.size() == 0) begin
                report_bad($sformatf("unexpected result: verdict %0d count %0d",
                                     out_if.verdict, out_if.compared_count));
            end else begin
                want = verdict_q.pop_front();
                if (want.verdict !== out_if.verdict ||
                    want.compared_count !== out_if.compared_count) begin
                    report_bad($sformatf(
                        "result mismatch: expected verdict %0d count %0d, got verdict %0d count %0d",
                        want.verdict, want.compared_count,
                        out_if.verdict, out_if.compared_count));
                end
            end
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_fire) begin
            if (pend_beats.size() != 0 &&
                (no_stall || $urandom_range(0, 99) >= IDLE_PCT)) begin
                t_beat b;
                b = pend_beats.pop_front();
                in_if.valid         <= 1'b1;
                in_if.action        <= b.action;
                in_if.window_start  <= b.window_start;
                in_if.page_rva      <= b.page_rva;
                in_if.entry_word    <= b.entry_word;
                in_if.last_in_block <= b.last_in_block;
                in_if.live_byte     <= b.live_byte;
                in_if.clean_byte    <= b.clean_byte;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        out_if.ready <= no_stall || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic t_beat noise_beat();
        t_beat b;
        b.action        = 3'($urandom_range(0, int'(ACT_MAX)));
        b.window_start  = $urandom;
        b.page_rva      = $urandom;
        b.entry_word    = 16'($urandom);
        b.last_in_block = 1'($urandom);
        b.live_byte     = 8'($urandom);
        b.clean_byte    = 8'($urandom);
        return b;
    endfunction

    task automatic queue_beat(t_beat b);
        pend_beats.push_back(b);
        if (b.action <= ACT_FINISH) begin
            n_items++;
        end
        if (b.action == ACT_FINISH) begin
            n_results++;
        end
    endtask

    task automatic queue_start(logic [31:0] w);
        t_beat b;
        b = noise_beat();
        b.action       = ACT_START;
        b.window_start = w;
        queue_beat(b);
    endtask

    task automatic queue_header(logic [31:0] p);
        t_beat b;
        b = noise_beat();
        b.action   = ACT_HEADER;
        b.page_rva = p;
        queue_beat(b);
        last_page = p;
    endtask

    task automatic queue_entry(logic [3:0] typ, logic [11:0] off, logic last);
        t_beat b;
        b = noise_beat();
        b.action        = ACT_ENTRY;
        b.entry_word    = {typ, off};
        b.last_in_block = last;
        queue_beat(b);
    endtask

    task automatic queue_pair(logic [7:0] live, logic [7:0] clean);
        t_beat b;
        b = noise_beat();
        b.action     = ACT_PAIR;
        b.live_byte  = live;
        b.clean_byte = clean;
        queue_beat(b);
    endtask

    task automatic queue_finish();
        t_beat b;
        b = noise_beat();
        b.action = ACT_FINISH;
        queue_beat(b);
    endtask

    // entry whose target lands on or near the window
    task automatic queue_near_entry(logic [31:0] win, bit new_hdr);
        logic [31:0] tgt;
        logic [11:0] off;
        logic [3:0]  typ;
        logic        last;
        int unsigned sel;
        tgt = win + 32'($urandom_range(0, WB + 8)) - 32'd4;
        off = 12'($urandom);
        if (new_hdr) begin
            queue_header($urandom_range(0, 7) == 0 ? $urandom : tgt - 32'(off));
        end else begin
            off = 12'(tgt - last_page);
        end
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            typ = TYP_ABS;
        end else if (sel <= 3) begin
            typ = TYP_HIGH;
        end else if (sel <= 6) begin
            typ = TYP_LOW;
        end else if (sel <= 11) begin
            typ = TYP_HIGHLOW;
        end else if (sel <= 15) begin
            typ = TYP_HIGHADJ;
        end else begin
            typ = 4'($urandom_range(int'(TYP_HIGHADJ) + 1, int'(TYP_MAX)));
        end
        last = (typ == TYP_HIGHADJ) ? ($urandom_range(0, 7) == 0) : 1'($urandom);
        queue_entry(typ, off, last);
        if (typ == TYP_HIGHADJ && !last) begin
            if ($urandom_range(0, 3) == 0) begin
                queue_header(last_page);
            end
            queue_entry(4'($urandom), 12'($urandom), 1'($urandom));
        end
    endtask

    task automatic queue_window();
        logic [31:0] win;
        logic [7:0]  lb;
        int unsigned sel;
        int unsigned n_ent;
        int unsigned n_pairs;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            win = 32'hFFFF_FFFF - 32'($urandom_range(0, 63));
        end else if (sel == 1) begin
            win = 32'($urandom_range(0, 63));
        end else begin
            win = $urandom;
        end
        queue_start(win);
        n_ent = $urandom_range(0, 8);
        for (int k = 0; k < n_ent; k++) begin
            queue_near_entry(win, k == 0 || $urandom_range(0, 2) == 0);
        end
        n_pairs = ($urandom_range(0, 4) == 0) ? $urandom_range(0, WB + 8) : WB;
        for (int p = 0; p < n_pairs; p++) begin
            if ($urandom_range(0, 49) == 0) begin
                queue_near_entry(win, 1'b1);
            end
            lb = 8'($urandom);
            queue_pair(lb, $urandom_range(0, 29) == 0 ? 8'($urandom) : lb);
        end
        queue_finish();
        if ($urandom_range(0, 9) == 0) begin
            queue_finish();
        end
    endtask

    task automatic queue_broken();
        logic [31:0] win;
        win = $urandom;
        queue_start(win);
        repeat ($urandom_range(0, 6)) queue_near_entry(win, $urandom_range(0, 1) == 0);
        repeat ($urandom_range(0, 8)) queue_pair(8'($urandom), 8'($urandom));
        queue_finish();
    endtask

    task automatic wait_drained();
        while (pend_beats.size() != 0 || in_if.valid || verdict_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_min(logic [5:0] v);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        m_min = v;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        cfg_wdata <= 6'($urandom);
    endtask

    task automatic run_phase(int unsigned want_items, int unsigned want_results);
        int unsigned item_goal;
        int unsigned result_goal;
        int unsigned r;
        item_goal   = n_items + want_items;
        result_goal = n_results + want_results;
        while (n_items < item_goal || n_results < result_goal) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                queue_window();
            end else if (r < 85) begin
                repeat ($urandom_range(1, 5)) queue_beat(noise_beat());
            end else begin
                queue_broken();
            end
        end
        wait_drained();
    endtask

    initial begin
        in_if.valid         = 1'b0;
        in_if.action        = ACT_START;
        in_if.window_start  = '0;
        in_if.page_rva      = '0;
        in_if.entry_word    = '0;
        in_if.last_in_block = 1'b0;
        in_if.live_byte     = '0;
        in_if.clean_byte    = '0;
        out_if.ready        = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        i_rst_n             = 1'b0;
        n_items   = 0;
        n_results = 0;
        n_errors  = 0;
        n_cycles  = 0;
        in_fire   = 1'b0;
        no_stall  = 1'b0;
        last_page = '0;
        m_win  = '0;
        m_blk  = '0;
        m_mask = '0;
        m_skip = 1'b0;
        m_pos  = 0;
        m_cnt  = 0;
        m_mism = 1'b0;
        m_perr = 1'b0;
        m_min  = MIN_CMP_RST;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // finish straight after reset, then ignored actions
        queue_finish();
        for (int a = int'(ACT_FINISH) + 1; a <= int'(ACT_MAX); a++) begin
            t_beat b;
            b = noise_beat();
            b.action = 3'(a);
            queue_beat(b);
        end

        // window at the top of the address space, running past the 32-bit edge, entries near it
        queue_start(32'hFFFF_FFF0);
        queue_header(32'hFFFF_F000);
        queue_entry(TYP_HIGH, 12'hFF0, 1'b0);
        queue_entry(TYP_HIGHADJ, 12'hFFC, 1'b0);
        queue_entry(4'd5, 12'hFF4, 1'b1);
        queue_entry(TYP_HIGHLOW, 12'hFFE, 1'b0);
        queue_entry(TYP_LOW, 12'hFFF, 1'b1);
        queue_entry(4'd9, 12'h000, 1'b0);
        for (int p = 0; p < WB + 2; p++) begin
            queue_pair(8'(p), p < 2 ? 8'(~p) : 8'(p));
        end
        queue_finish();
        queue_finish();

        // overflowing target and a trailing adjust entry
        queue_start(32'h0000_0000);
        queue_header(32'hFFFF_FFFF);
        queue_entry(TYP_ABS, 12'h001, 1'b0);
        queue_header(32'h0000_0000);
        queue_entry(TYP_HIGHADJ, 12'h004, 1'b1);
        queue_pair(8'hFF, 8'hFF);
        queue_finish();

        // header clears a pending skip, late entry, unmasked mismatch
        queue_start(32'h0000_0100);
        queue_header(32'h0000_0100);
        queue_entry(TYP_HIGHADJ, 12'h000, 1'b0);
        queue_header(32'h0000_0100);
        queue_entry(TYP_HIGHLOW, 12'h008, 1'b0);
        queue_entry(TYP_MAX, 12'h200, 1'b1);
        for (int p = 0; p < WB; p++) begin
            if (p == 10) begin
                queue_entry(TYP_HIGH, 12'h119, 1'b0);
            end
            queue_pair(8'h00, p == 20 ? 8'h80 : 8'h00);
        end
        queue_finish();
        wait_drained();

        write_min(6'd32);
        no_stall = 1'b1;
        run_phase(110, 3);
        no_stall = 1'b0;
        write_min(6'd1);
        run_phase(110, 3);
        write_min(6'd0);
        run_phase(110, 3);
        write_min(6'd63);
        run_phase(110, 3);
        write_min(6'd33);
        run_phase(110, 3);
        write_min(6'($urandom_range(1, WB)));
        run_phase(110, 3);

        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/rmwc_pkg.sv
src/rmwc_in_if.sv
src/rmwc_out_if.sv
src/rmwc_front.sv
src/rmwc_queue.sv
src/rmwc_back.sv
src/relocation_masked_window_compare.sv
bench/relocation_masked_window_compare_test.sv
